FILE: rtl/linear_fade_gain_core_defines.svh
// ----------------------------------------------------------------------------
// linear fade gain core: assertion macros
// shared property forms for the concurrent checks of the fade gain core
// ----------------------------------------------------------------------------
`ifndef LINEAR_FADE_GAIN_CORE_DEFINES_SVH
`define LINEAR_FADE_GAIN_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LFG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LFG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lfg_pkg.sv
// ----------------------------------------------------------------------------
// lfg_pkg
// widths, constants and types of the linear fade gain core
// ----------------------------------------------------------------------------
package lfg_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int MAX_CHANNELS = 8;
    localparam int FRAME_BITS   = 16;
    localparam int VOL_BITS     = 19;
    localparam int CCNT_BITS    = 4;
    localparam int CHAN_BITS    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int GAIN_BITS    = 17;

    // frame times volume difference
    localparam int DIFF_BITS    = VOL_BITS + 1;
    localparam int PROD_BITS    = FRAME_BITS + DIFF_BITS + 1;
    localparam int MAG_BITS     = PROD_BITS - 1;

    // radix-4 divider: two quotient bits per step
    localparam int DIV_STEPS    = (MAG_BITS + 1) / 2;
    localparam int DIV_BITS     = 2 * DIV_STEPS;
    localparam int DSTEP_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int SUM_BITS     = DIV_BITS + 2;

    localparam int GAIN_ONE     = 65536;
    localparam int BYPASS_LEVEL = 65530;
    localparam int GAIN_SHIFT   = 16;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    localparam logic [VOL_BITS-1:0]   START_VOL_RST = VOL_BITS'(GAIN_ONE);
    localparam logic [VOL_BITS-1:0]   END_VOL_RST   = VOL_BITS'(GAIN_ONE);
    localparam logic [FRAME_BITS-1:0] FRAME_CNT_RST = FRAME_BITS'(1024);
    localparam logic [CCNT_BITS-1:0]  CHAN_CNT_RST  = CCNT_BITS'(2);

    typedef enum logic [1:0] {
        REG_START_VOL,
        REG_END_VOL,
        REG_FRAME_COUNT,
        REG_CHANNEL_COUNT
    } lfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_LOAD,
        ST_DIV,
        ST_GAIN,
        ST_SCALE
    } lfg_state_t;

endpackage

FILE: rtl/lfg_div.sv
// ----------------------------------------------------------------------------
// lfg_div
// iterative unsigned divider, restoring, two quotient bits per cycle
// ----------------------------------------------------------------------------
module lfg_div
    import lfg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIV_BITS-1:0]   dividend,
    input  logic [FRAME_BITS-1:0] divisor,
    output logic                  done,
    output logic [DIV_BITS-1:0]   quotient
);

    logic [FRAME_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0]   quo_reg, quo_next;
    logic [DSTEP_BITS-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [FRAME_BITS:0]   try1, try2;
    logic [FRAME_BITS-1:0] r1;
    logic                  b1, b2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_comb begin
        // first bit of the step
        try1 = {rem_reg, quo_reg[DIV_BITS-1]};
        b1   = (try1 >= {1'b0, divisor});
        r1   = b1 ? FRAME_BITS'(try1 - {1'b0, divisor}) : try1[FRAME_BITS-1:0];
        // second bit of the step
        try2 = {r1, quo_reg[DIV_BITS-2]};
        b2   = (try2 >= {1'b0, divisor});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = b2 ? FRAME_BITS'(try2 - {1'b0, divisor}) : try2[FRAME_BITS-1:0];
            quo_next = {quo_reg[DIV_BITS-3:0], b1, b2};
            cnt_next = DSTEP_BITS'(cnt_reg + 1'b1);
            if (cnt_reg == DSTEP_BITS'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/linear_fade_gain_core.sv
// ----------------------------------------------------------------------------
// linear_fade_gain_core
// linear volume fade over an interleaved audio buffer, one sample per word
// ----------------------------------------------------------------------------
//  port group  direction  contents
//  s_axis      in         tdata[23:0] sample_in
//  m_axis      out        tdata[23:0] sample_out, tlast buffer_end
//  apb         in/out     start_volume, end_volume, frame_count, channel_count
//
//  one sample passes from accept to result through the product, divider load,
//  18 divider steps of two bits, gain clamp and the sample multiply.
//  a new sample is taken only after the current one enters the output register.
//  s_tready is high only in idle; a result waiting in the output register
//  does not block the next sample, only the final load of the one after it.
//  aresetn is synchronous: registers to their reset values, counters to zero.
// ----------------------------------------------------------------------------
`include "linear_fade_gain_core_defines.svh"

module linear_fade_gain_core
    import lfg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // sample_in [23:0]
    input  logic [23:0]              s_tdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // sample_out [23:0]
    output logic [23:0]              m_tdata,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    // configuration
    logic [VOL_BITS-1:0]   start_vol_reg;
    logic [VOL_BITS-1:0]   end_vol_reg;
    logic [FRAME_BITS-1:0] frame_cnt_reg;
    logic [CCNT_BITS-1:0]  chan_cnt_reg;
    lfg_reg_t              reg_sel;
    logic                  cfg_wr;

    // sequencer and position
    lfg_state_t            state_reg, state_next;
    logic [FRAME_BITS-1:0] frame_pos_reg, frame_pos_next;
    logic [CHAN_BITS-1:0]  chan_pos_reg, chan_pos_next;

    // item in flight
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [FRAME_BITS-1:0]  frame_cap_reg, frame_cap_next;
    logic                   last_reg, last_next;
    logic [DIV_BITS-1:0]    mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                   out_last_reg, out_last_next;

    logic                   div_start;
    logic                   div_done;
    logic [DIV_BITS-1:0]    quotient;
    logic [FRAME_BITS-1:0]  divisor;

    logic [CCNT_BITS-1:0]   chans;
    logic [FRAME_BITS-1:0]  frames;
    logic                   last_chan, last_frame;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [PROD_BITS-1:0]   prod;
    logic [PROD_BITS-1:0]          prod_abs;
    logic signed [SUM_BITS-1:0]    q_signed;
    logic signed [SUM_BITS-1:0]    gain_sum;
    logic signed [SAMPLE_BITS+GAIN_BITS:0] scaled;
    logic                   bypass;
    logic                   out_free;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = lfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_vol_reg <= START_VOL_RST;
            end_vol_reg   <= END_VOL_RST;
            frame_cnt_reg <= FRAME_CNT_RST;
            chan_cnt_reg  <= CHAN_CNT_RST;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_START_VOL:     start_vol_reg <= pwdata[VOL_BITS-1:0];
                REG_END_VOL:       end_vol_reg   <= pwdata[VOL_BITS-1:0];
                REG_FRAME_COUNT:   frame_cnt_reg <= pwdata[FRAME_BITS-1:0];
                REG_CHANNEL_COUNT: chan_cnt_reg  <= pwdata[CCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_START_VOL:
                prdata = {{(APB_DATA_BITS-VOL_BITS){start_vol_reg[VOL_BITS-1]}},
                          start_vol_reg};
            REG_END_VOL:
                prdata = {{(APB_DATA_BITS-VOL_BITS){end_vol_reg[VOL_BITS-1]}},
                          end_vol_reg};
            REG_FRAME_COUNT:
                prdata = {{(APB_DATA_BITS-FRAME_BITS){1'b0}}, frame_cnt_reg};
            REG_CHANNEL_COUNT:
                prdata = {{(APB_DATA_BITS-CCNT_BITS){1'b0}}, chan_cnt_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // shared divider
    // ------------------------------------------------------------------
    // zero frame count keeps the start volume; the quotient is dropped then
    assign divisor = (frame_cnt_reg == '0) ? FRAME_BITS'(1) : frame_cnt_reg;

    lfg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            frame_pos_reg <= '0;
            chan_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            frame_pos_reg <= frame_pos_next;
            chan_pos_reg  <= chan_pos_next;
            out_valid_reg <= out_valid_next;
        end
        sample_reg     <= sample_next;
        frame_cap_reg  <= frame_cap_next;
        last_reg       <= last_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        gain_reg       <= gain_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    always_comb begin
        if (chan_cnt_reg == '0) begin
            chans = CCNT_BITS'(1);
        end else if (chan_cnt_reg > CCNT_BITS'(MAX_CHANNELS)) begin
            chans = CCNT_BITS'(MAX_CHANNELS);
        end else begin
            chans = chan_cnt_reg;
        end
        frames     = (frame_cnt_reg == '0) ? FRAME_BITS'(1) : frame_cnt_reg;
        last_chan  = (CCNT_BITS'(chan_pos_reg) + CCNT_BITS'(1)) >= chans;
        last_frame = ({1'b0, frame_pos_reg} + 1'b1) >= {1'b0, frames};

        diff     = DIFF_BITS'($signed(end_vol_reg)) - DIFF_BITS'($signed(start_vol_reg));
        prod     = $signed({1'b0, frame_cap_reg}) * diff;
        prod_abs = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : PROD_BITS'(prod);

        q_signed = neg_reg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
        if (frame_cnt_reg == '0) begin
            q_signed = '0;
        end
        gain_sum = SUM_BITS'($signed(start_vol_reg)) + q_signed;

        scaled   = $signed(sample_reg) * $signed({1'b0, gain_reg});
        bypass   = ($signed(start_vol_reg) >= $signed(VOL_BITS'(BYPASS_LEVEL))) &&
                   ($signed(end_vol_reg)   >= $signed(VOL_BITS'(BYPASS_LEVEL)));
        out_free = !out_valid_reg || m_tready;
    end

    always_comb begin
        state_next      = state_reg;
        frame_pos_next  = frame_pos_reg;
        chan_pos_next   = chan_pos_reg;
        sample_next     = sample_reg;
        frame_cap_next  = frame_cap_reg;
        last_next       = last_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        gain_next       = gain_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        div_start       = 1'b0;
        s_tready        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sample_next    = s_tdata;
                    frame_cap_next = frame_pos_reg;
                    last_next      = last_chan && last_frame;
                    if (last_chan) begin
                        chan_pos_next  = '0;
                        frame_pos_next = last_frame ? '0
                                       : FRAME_BITS'(frame_pos_reg + 1'b1);
                    end else begin
                        chan_pos_next = CHAN_BITS'(chan_pos_reg + 1'b1);
                    end
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                mag_next   = DIV_BITS'(prod_abs[MAG_BITS-1:0]);
                neg_next   = prod[PROD_BITS-1];
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                // clamp to [0, 1.0]
                if (gain_sum[SUM_BITS-1]) begin
                    gain_next = '0;
                end else if (gain_sum > $signed(SUM_BITS'(GAIN_ONE))) begin
                    gain_next = GAIN_BITS'(GAIN_ONE);
                end else begin
                    gain_next = gain_sum[GAIN_BITS-1:0];
                end
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (out_free) begin
                    out_sample_next = bypass ? sample_reg
                                    : scaled[GAIN_SHIFT+SAMPLE_BITS-1:GAIN_SHIFT];
                    out_last_next   = last_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tdata  = out_sample_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `LFG_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken while a sample is still in work")
    `LFG_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV, "divider finished outside the divide phase")
    `LFG_ASSERT_NOW(a_gain_clamped, aclk, aresetn, state_reg == ST_SCALE, gain_reg <= GAIN_BITS'(GAIN_ONE), "frame gain above unity")

endmodule
